// ===== rtl/nearest_neighbor_scale_address_gen_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the nearest neighbor scaling address generator
// Clocked on i_clk, disabled while i_rst_n is low.
// ---------------------------------------------------------------------------
`ifndef NEAREST_NEIGHBOR_SCALE_ADDRESS_GEN_ASSERT_SVH
`define NEAREST_NEIGHBOR_SCALE_ADDRESS_GEN_ASSERT_SVH
`ifndef NO_ASSERTIONS
// antecedent implies consequent in the same cycle
`define NNSAG_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("nnsag check failed");
// condition must never hold
`define NNSAG_ASSERT_NEVER(name, expr) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("nnsag check failed");
`else
`define NNSAG_ASSERT_IMPLY(name, ante, cons)
`define NNSAG_ASSERT_NEVER(name, expr)
`endif
`endif

// ===== rtl/nnsag_pkg.sv =====
// ---------------------------------------------------------------------------
// nnsag_pkg
// Shared types and constants of the scaling address generator.
// ---------------------------------------------------------------------------
package nnsag_pkg;

    localparam int DimW    = 13;
    localparam int StrideW = 15;
    localparam int BufW    = 28;
    localparam int SrcOffW = 26;
    localparam int AddrW   = 5;
    localparam int DataW   = 32;
    localparam int DivLat  = DimW;     // one quotient bit per stage
    localparam int MaxDim  = 8192;
    localparam logic [DimW-1:0] DimMax = DimW'(MaxDim - 1);

    // register indexes
    typedef enum logic [2:0] {
        REG_SRC_W, REG_SRC_H, REG_PHYS_W, REG_PHYS_H,
        REG_REP_W, REG_REP_H, REG_STRIDE, REG_BUF
    } t_reg_idx;

    typedef struct packed {
        logic [DimW-1:0] dest_x;
        logic [DimW-1:0] dest_y;
    } t_in_word;

    typedef struct packed {
        logic               in_range;
        logic [SrcOffW-1:0] src_offset;
        logic [BufW-1:0]    dst_offset;
        logic [DimW-1:0]    eff_width;
        logic [DimW-1:0]    eff_height;
    } t_out_word;

    typedef struct packed {
        logic [DimW-1:0]    src_width;
        logic [DimW-1:0]    src_height;
        logic [DimW-1:0]    phys_width;
        logic [DimW-1:0]    phys_height;
        logic [DimW-1:0]    rep_width;
        logic [DimW-1:0]    rep_height;
        logic [StrideW-1:0] row_pitch;
        logic [BufW-1:0]    buffer_bytes;
    } t_cfg;

endpackage

// ===== rtl/nnsag_cfg.sv =====
// ---------------------------------------------------------------------------
// nnsag_cfg
// APB register file holding the geometry registers.
// ---------------------------------------------------------------------------
module nnsag_cfg
    import nnsag_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready,
    output t_cfg             o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx idx;

    assign idx    = t_reg_idx'(paddr[AddrW-1:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.src_width    <= DimW'(1920);
            r_cfg.src_height   <= DimW'(1080);
            r_cfg.phys_width   <= '0;
            r_cfg.phys_height  <= '0;
            r_cfg.rep_width    <= '0;
            r_cfg.rep_height   <= '0;
            r_cfg.row_pitch    <= '0;
            r_cfg.buffer_bytes <= '0;
        end else if (psel && penable && pwrite) begin
            case (idx)
                REG_SRC_W:  r_cfg.src_width    <= pwdata[DimW-1:0];
                REG_SRC_H:  r_cfg.src_height   <= pwdata[DimW-1:0];
                REG_PHYS_W: r_cfg.phys_width   <= pwdata[DimW-1:0];
                REG_PHYS_H: r_cfg.phys_height  <= pwdata[DimW-1:0];
                REG_REP_W:  r_cfg.rep_width    <= pwdata[DimW-1:0];
                REG_REP_H:  r_cfg.rep_height   <= pwdata[DimW-1:0];
                REG_STRIDE: r_cfg.row_pitch    <= pwdata[StrideW-1:0];
                REG_BUF:    r_cfg.buffer_bytes <= pwdata[BufW-1:0];
                default: ;
            endcase
        end
    end

    // readback
    always_comb begin
        case (idx)
            REG_SRC_W:  prdata = DataW'(r_cfg.src_width);
            REG_SRC_H:  prdata = DataW'(r_cfg.src_height);
            REG_PHYS_W: prdata = DataW'(r_cfg.phys_width);
            REG_PHYS_H: prdata = DataW'(r_cfg.phys_height);
            REG_REP_W:  prdata = DataW'(r_cfg.rep_width);
            REG_REP_H:  prdata = DataW'(r_cfg.rep_height);
            REG_STRIDE: prdata = DataW'(r_cfg.row_pitch);
            REG_BUF:    prdata = DataW'(r_cfg.buffer_bytes);
            default:    prdata = '0;
        endcase
    end

endmodule

// ===== rtl/nnsag_div.sv =====
// ---------------------------------------------------------------------------
// nnsag_div
// Pipelined restoring divider, one quotient bit per stage, 13 stages.
// Dividend must be below divisor * 2^13.
// ---------------------------------------------------------------------------
module nnsag_div
    import nnsag_pkg::*;
(
    input  logic               i_clk,
    input  logic [BufW-1:0]    i_dividend,
    input  logic [StrideW-1:0] i_divisor,
    output logic [DimW-1:0]    o_quotient
);

    logic [StrideW-1:0] r_rem [DivLat];
    logic [DimW-1:0]    r_low [DivLat];
    logic [DimW-1:0]    r_quo [DivLat];
    logic [StrideW-1:0] r_dsr [DivLat];
    logic [StrideW-1:0] n_rem [DivLat];
    logic [DimW-1:0]    n_low [DivLat];
    logic [DimW-1:0]    n_quo [DivLat];
    logic [StrideW-1:0] n_dsr [DivLat];
    logic [StrideW-1:0] s_rem [DivLat];
    logic [DimW-1:0]    s_low [DivLat];
    logic [DimW-1:0]    s_quo [DivLat];
    logic [StrideW-1:0] s_dsr [DivLat];

    // stage inputs: first stage from the ports, the rest from the previous stage
    always_comb begin
        s_rem[0] = i_dividend[BufW-1:DimW];
        s_low[0] = i_dividend[DimW-1:0];
        s_quo[0] = '0;
        s_dsr[0] = i_divisor;
        for (int k = 1; k < DivLat; k++) begin
            s_rem[k] = r_rem[k-1];
            s_low[k] = r_low[k-1];
            s_quo[k] = r_quo[k-1];
            s_dsr[k] = r_dsr[k-1];
        end
    end

    // one compare/subtract per stage
    always_comb begin
        logic [StrideW:0] trial;
        logic             ge;
        for (int k = 0; k < DivLat; k++) begin
            trial    = {s_rem[k], s_low[k][DimW-1]};
            ge       = trial >= {1'b0, s_dsr[k]};
            n_rem[k] = ge ? StrideW'(trial - {1'b0, s_dsr[k]}) : trial[StrideW-1:0];
            n_low[k] = {s_low[k][DimW-2:0], 1'b0};
            n_quo[k] = {s_quo[k][DimW-2:0], ge};
            n_dsr[k] = s_dsr[k];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DivLat; k++) begin
            r_rem[k] <= n_rem[k];
            r_low[k] <= n_low[k];
            r_quo[k] <= n_quo[k];
            r_dsr[k] <= n_dsr[k];
        end
    end

    assign o_quotient = r_quo[DivLat-1];

endmodule

// ===== rtl/nearest_neighbor_scale_address_gen.sv =====
// o_done pulses once start has passed the valid registers r_va, r_vb, r_vc, r_vd, r_done.
// Throughput: one word per clock; busy is always low.
// Depth is set by two 13-stage bit-per-stage dividers in series (rows, then
// source x/y), plus three arithmetic stages.
// Reset (synchronous, active low) clears all valid bits and reloads the
// configuration registers; data stages are not cleared.
// ---------------------------------------------------------------------------
// nearest_neighbor_scale_address_gen
// Maps a destination pixel to source and destination byte offsets.
// ---------------------------------------------------------------------------
`include "nearest_neighbor_scale_address_gen_assert.svh"
module nearest_neighbor_scale_address_gen
    import nnsag_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_in_word         i_in,
    output logic             o_done,
    output t_out_word        o_result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [AddrW-1:0] paddr,
    input  logic [DataW-1:0] pwdata,
    output logic [DataW-1:0] prdata,
    output logic             pready
);

    typedef struct packed {
        logic            bad;
        logic            nocap;
        logic [DimW-1:0] dx;
        logic [DimW-1:0] dy;
        logic [DimW-1:0] bw;
        logic [DimW-1:0] bh;
    } t_side_a;

    typedef struct packed {
        logic            bad;
        logic            in_range;
        logic [DimW-1:0] dx;
        logic [DimW-1:0] dy;
        logic [DimW-1:0] bw;
        logic [DimW-1:0] bh;
    } t_side_b;

    typedef struct packed {
        logic               bad;
        logic               in_range;
        logic [DimW-1:0]    dx;
        logic [DimW-1:0]    sx;
        logic [DimW-1:0]    bw;
        logic [DimW-1:0]    bh;
        logic [SrcOffW-1:0] sy_pitch;
        logic [BufW-1:0]    dy_pitch;
    } t_side_d;

    t_cfg            cfg;
    t_side_a         n_a;
    t_side_a         r_pa [DivLat];
    logic            r_va [DivLat];
    logic [DimW-1:0] q_rows;
    t_side_b         n_b, r_b;
    logic            r_vb;
    logic [2*DimW-1:0] r_px, r_py;
    t_side_b         r_pc [DivLat];
    logic            r_vc [DivLat];
    logic [DimW-1:0] q_sx, q_sy;
    t_side_d         r_d;
    logic            r_vd;
    logic [StrideW-1:0] pitch;
    t_out_word       r_res;
    logic            r_done;

    assign busy = 1'b0;

    nnsag_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // stage A: size selection, rep and column clamps
    always_comb begin
        logic [DimW-1:0] bw, bh, cols;
        if (cfg.phys_width != '0 && cfg.phys_height != '0) begin
            bw = cfg.phys_width;
            bh = cfg.phys_height;
        end else begin
            bw = cfg.src_width;
            bh = cfg.src_height;
        end
        n_a.bad = (bw == '0) || (bh == '0);
        if (cfg.rep_width != '0 && cfg.rep_height != '0) begin
            if (cfg.rep_width < bw)  bw = cfg.rep_width;
            if (cfg.rep_height < bh) bh = cfg.rep_height;
        end
        cols = cfg.row_pitch[StrideW-1:2];
        if (cfg.row_pitch != '0 && cols != '0 && bw > cols) bw = cols;
        if (bw > DimMax) bw = DimMax;
        n_a.bw    = bw;
        n_a.bh    = bh;
        n_a.dx    = i_in.dest_x;
        n_a.dy    = i_in.dest_y;
        // row count of 8192 or more never clamps
        n_a.nocap = (cfg.row_pitch == '0) ||
                    (cfg.buffer_bytes >= {cfg.row_pitch, {DimW{1'b0}}});
    end

    // rows = buffer_bytes / stride, aligned with the side line
    nnsag_div u_div_rows (
        .i_clk      (i_clk),
        .i_dividend (cfg.buffer_bytes),
        .i_divisor  (cfg.row_pitch),
        .o_quotient (q_rows)
    );

    always_ff @(posedge i_clk) begin
        r_pa[0] <= n_a;
        for (int k = 1; k < DivLat; k++) begin
            r_pa[k] <= r_pa[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DivLat; k++) r_va[k] <= 1'b0;
        end else begin
            r_va[0] <= start;
            for (int k = 1; k < DivLat; k++) r_va[k] <= r_va[k-1];
        end
    end

    // stage B: row clamp, range check, scaled numerators
    always_comb begin
        n_b.bad = r_pa[DivLat-1].bad;
        n_b.dx  = r_pa[DivLat-1].dx;
        n_b.dy  = r_pa[DivLat-1].dy;
        n_b.bw  = r_pa[DivLat-1].bw;
        n_b.bh  = r_pa[DivLat-1].bh;
        if (!r_pa[DivLat-1].nocap && q_rows != '0 && n_b.bh > q_rows) n_b.bh = q_rows;
        if (n_b.bh > DimMax) n_b.bh = DimMax;
        n_b.in_range = !n_b.bad && (n_b.dx < n_b.bw) && (n_b.dy < n_b.bh);
    end

    always_ff @(posedge i_clk) begin
        r_b  <= n_b;
        r_px <= (2*DimW)'(n_b.dx) * (2*DimW)'(cfg.src_width);
        r_py <= (2*DimW)'(n_b.dy) * (2*DimW)'(cfg.src_height);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
        end else begin
            r_vb <= r_va[DivLat-1];
        end
    end

    // source column and row dividers
    nnsag_div u_div_x (
        .i_clk      (i_clk),
        .i_dividend (BufW'(r_px)),
        .i_divisor  (StrideW'(r_b.bw)),
        .o_quotient (q_sx)
    );

    nnsag_div u_div_y (
        .i_clk      (i_clk),
        .i_dividend (BufW'(r_py)),
        .i_divisor  (StrideW'(r_b.bh)),
        .o_quotient (q_sy)
    );

    always_ff @(posedge i_clk) begin
        r_pc[0] <= r_b;
        for (int k = 1; k < DivLat; k++) begin
            r_pc[k] <= r_pc[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DivLat; k++) r_vc[k] <= 1'b0;
        end else begin
            r_vc[0] <= r_vb;
            for (int k = 1; k < DivLat; k++) r_vc[k] <= r_vc[k-1];
        end
    end

    // stage C: pitch products
    assign pitch = (cfg.row_pitch != '0) ? cfg.row_pitch
                                         : {r_pc[DivLat-1].bw, 2'b00};

    always_ff @(posedge i_clk) begin
        r_d.bad      <= r_pc[DivLat-1].bad;
        r_d.in_range <= r_pc[DivLat-1].in_range;
        r_d.dx       <= r_pc[DivLat-1].dx;
        r_d.sx       <= q_sx;
        r_d.bw       <= r_pc[DivLat-1].bw;
        r_d.bh       <= r_pc[DivLat-1].bh;
        r_d.sy_pitch <= SrcOffW'(q_sy) * SrcOffW'(cfg.src_width);
        r_d.dy_pitch <= BufW'(r_pc[DivLat-1].dy) * BufW'(pitch);
    end

    // stage D: offset sums and output word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vd   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_vd   <= r_vc[DivLat-1];
            r_done <= r_vd;
        end
    end

    always_ff @(posedge i_clk) begin
        r_res.in_range   <= r_d.in_range;
        r_res.src_offset <= r_d.in_range
            ? {(SrcOffW-2)'(r_d.sy_pitch + SrcOffW'(r_d.sx)), 2'b00} : '0;
        r_res.dst_offset <= r_d.in_range
            ? BufW'(r_d.dy_pitch + BufW'({r_d.dx, 2'b00})) : '0;
        r_res.eff_width  <= r_d.bad ? '0 : r_d.bw;
        r_res.eff_height <= r_d.bad ? '0 : r_d.bh;
    end

    assign o_done   = r_done;
    assign o_result = r_res;

    `NNSAG_ASSERT_IMPLY(a_done_from_start, o_done, $past(start, 29))
    `NNSAG_ASSERT_NEVER(a_oor_zero, o_done && !o_result.in_range &&
        (o_result.src_offset != '0 || o_result.dst_offset != '0))
    `NNSAG_ASSERT_IMPLY(a_inrange_size, o_done && o_result.in_range,
        o_result.eff_width != '0 && o_result.eff_height != '0)

endmodule
